### design/pbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon boundary clip package
// Shared constants, register indexes, step codes and sequencer states.
// ----------------------------------------------------------------------------
package pbc_pkg;

  localparam int COORD_BITS_DEF = 24;

  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SIDE  = 1'b0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BOUND = 1'b1;

  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_TOP    = 2'd2,
    SIDE_BOTTOM = 2'd3
  } side_t;

  localparam int STEP_BITS = 5;
  typedef logic [STEP_BITS-1:0] step_t;
  localparam step_t STEP_NONE    = 5'h00;
  localparam step_t STEP_A_CROSS = 5'h01;
  localparam step_t STEP_A_VERT  = 5'h02;
  localparam step_t STEP_B_CROSS = 5'h04;
  localparam step_t STEP_B_VERT  = 5'h08;
  localparam step_t STEP_MARK    = 5'h10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PICK,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_ROUND,
    ST_EMIT
  } state_t;

endpackage

### design/polygon_boundary_clip_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Polygon boundary clip stage
// One clipping pass of a polygon against an axis-aligned boundary, with a
// shared multiply and restoring divide unit for the crossing points.
// ----------------------------------------------------------------------------
//  Channel   Handshake              Carries
//  in        in_valid / in_ready    vert_x, vert_y, poly_last
//  out       out_valid / out_ready  out_x, out_y, has_vertex, is_crossing, poly_end
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  Each crossing also passes through the setup, multiply, bit-serial divide and round states.
//  A polygon's final vertex can cause up to three results.
//  Reset is synchronous; configuration is reset to the left side at zero.
//  A stalled output holds the sequencer; in_ready is high only when idle.
// ----------------------------------------------------------------------------
module polygon_boundary_clip_stage #(
  parameter int COORD_BITS = pbc_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [COORD_BITS-1:0]          vert_x,
  input  logic signed [COORD_BITS-1:0]          vert_y,
  input  logic                                  poly_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [COORD_BITS-1:0]          out_x,
  output logic signed [COORD_BITS-1:0]          out_y,
  output logic                                  has_vertex,
  output logic                                  is_crossing,
  output logic                                  poly_end,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [pbc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  logic [COORD_BITS-1:0]                 cfg_data
);

  localparam int W        = COORD_BITS;
  localparam int CNT_BITS = $clog2(W);

  function automatic logic inside_pt(input pbc_pkg::side_t s,
                                     input logic signed [W-1:0] b,
                                     input logic signed [W-1:0] x,
                                     input logic signed [W-1:0] y);
    logic r;
    unique case (s)
      pbc_pkg::SIDE_LEFT:  r = (x >= b);
      pbc_pkg::SIDE_RIGHT: r = (x <= b);
      pbc_pkg::SIDE_TOP:   r = (y >= b);
      default:             r = (y <= b);
    endcase
    return r;
  endfunction

  pbc_pkg::side_t        side;
  logic signed [W-1:0]   bound;

  pbc_pkg::state_t       state, state_next;
  pbc_pkg::step_t        mask, mask_next;
  pbc_pkg::step_t        step, step_next;
  logic [CNT_BITS-1:0]   cnt, cnt_next;

  logic                  have_first;
  logic signed [W-1:0]   first_x, first_y, prev_x, prev_y;
  logic signed [W-1:0]   sa_x, sa_y, pa_x, pa_y;
  logic                  a_p_in, b_p_in, last_r;

  logic [W-1:0]          mag_t, mag_dv, dm;
  logic                  neg;
  logic signed [W-1:0]   av_r;
  logic [W-1:0]          rem, quo;

  logic signed [W-1:0]   res_x, res_y;
  logic                  res_hv, res_cr;

  logic                  accept, emit_fire, y_axis;
  logic                  cur_in, prv_in, fst_in, s_in;
  logic                  a_cr, a_vt, b_cr, b_vt, a_on, b_on;
  pbc_pkg::step_t        plan, low_bit;

  logic                  edge_b, ep_in;
  logic signed [W-1:0]   es_x, es_y, ep_x, ep_y, ix_x, ix_y, ox_x, ox_y;
  logic signed [W-1:0]   au, av, bu, bv;
  logic signed [W:0]     t_d, dv_d, d_d;
  logic [W:0]            t_m, dv_m, d_m;
  logic [2*W-1:0]        prod;
  logic [W:0]            trial, diff, twice_r, mag_q;
  logic                  ge, inc;
  logic signed [W:0]     sum;
  logic signed [W-1:0]   cross_c;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == pbc_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign y_axis    = (side == pbc_pkg::SIDE_TOP) || (side == pbc_pkg::SIDE_BOTTOM);

  always_ff @(posedge clk) begin
    if (rst) begin
      side  <= pbc_pkg::SIDE_LEFT;
      bound <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbc_pkg::REG_SIDE:  side  <= pbc_pkg::side_t'(cfg_data[1:0]);
        pbc_pkg::REG_BOUND: bound <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result plan of the item, worked out from the inside tests on acceptance.
  always_comb begin
    cur_in = inside_pt(side, bound, vert_x, vert_y);
    prv_in = inside_pt(side, bound, prev_x, prev_y);
    fst_in = inside_pt(side, bound, first_x, first_y);
    s_in   = have_first ? prv_in : cur_in;
    a_on   = have_first || poly_last;
    b_on   = have_first && poly_last;
    a_cr   = a_on && (cur_in ? !s_in : s_in);
    a_vt   = a_on && cur_in;
    b_cr   = b_on && (fst_in ? !cur_in : cur_in);
    b_vt   = b_on && fst_in;
    plan   = (a_cr ? pbc_pkg::STEP_A_CROSS : pbc_pkg::STEP_NONE)
           | (a_vt ? pbc_pkg::STEP_A_VERT  : pbc_pkg::STEP_NONE)
           | (b_cr ? pbc_pkg::STEP_B_CROSS : pbc_pkg::STEP_NONE)
           | (b_vt ? pbc_pkg::STEP_B_VERT  : pbc_pkg::STEP_NONE);
    if (poly_last && (plan == pbc_pkg::STEP_NONE)) begin
      plan = pbc_pkg::STEP_MARK;
    end
    low_bit = mask & (~mask + pbc_pkg::STEP_BITS'(1));
  end

  // Crossing operands: the inside end comes first, u is the clipped axis.
  always_comb begin
    edge_b = (step == pbc_pkg::STEP_B_CROSS);
    es_x   = edge_b ? pa_x : sa_x;
    es_y   = edge_b ? pa_y : sa_y;
    ep_x   = edge_b ? first_x : pa_x;
    ep_y   = edge_b ? first_y : pa_y;
    ep_in  = edge_b ? b_p_in : a_p_in;
    ix_x   = ep_in ? ep_x : es_x;
    ix_y   = ep_in ? ep_y : es_y;
    ox_x   = ep_in ? es_x : ep_x;
    ox_y   = ep_in ? es_y : ep_y;
    au     = y_axis ? ix_y : ix_x;
    av     = y_axis ? ix_x : ix_y;
    bu     = y_axis ? ox_y : ox_x;
    bv     = y_axis ? ox_x : ox_y;
    t_d    = {bound[W-1], bound} - {au[W-1], au};
    dv_d   = {bv[W-1], bv} - {av[W-1], av};
    d_d    = {bu[W-1], bu} - {au[W-1], au};
    t_m    = t_d[W] ? (W + 1)'(0) - t_d : t_d;
    dv_m   = dv_d[W] ? (W + 1)'(0) - dv_d : dv_d;
    d_m    = d_d[W] ? (W + 1)'(0) - d_d : d_d;
  end

  always_comb begin
    prod    = mag_t * mag_dv;
    trial   = {rem, quo[W-1]};
    diff    = trial - {1'b0, dm};
    ge      = (trial >= {1'b0, dm});
    twice_r = {rem, 1'b0};
    inc     = neg ? (twice_r > {1'b0, dm}) : (twice_r >= {1'b0, dm});
    mag_q   = {1'b0, quo} + (W + 1)'(inc);
    sum     = neg ? ({av_r[W-1], av_r} - $signed(mag_q))
                  : ({av_r[W-1], av_r} + $signed(mag_q));
    cross_c = (dm == '0) ? av_r : sum[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pbc_pkg::ST_IDLE;
      mask       <= pbc_pkg::STEP_NONE;
      step       <= pbc_pkg::STEP_NONE;
      cnt        <= '0;
      have_first <= 1'b0;
    end else begin
      state <= state_next;
      mask  <= mask_next;
      step  <= step_next;
      cnt   <= cnt_next;
      if (accept) begin
        have_first <= !poly_last;
      end
    end
  end

  always_comb begin
    state_next = state;
    mask_next  = mask;
    step_next  = step;
    cnt_next   = cnt;
    emit_fire  = 1'b0;
    unique case (state)
      pbc_pkg::ST_IDLE: begin
        if (accept) begin
          mask_next  = plan;
          state_next = pbc_pkg::ST_PICK;
        end
      end
      pbc_pkg::ST_PICK: begin
        step_next = low_bit;
        if (mask == pbc_pkg::STEP_NONE) begin
          state_next = pbc_pkg::ST_IDLE;
        end else if (low_bit == pbc_pkg::STEP_A_CROSS || low_bit == pbc_pkg::STEP_B_CROSS) begin
          state_next = pbc_pkg::ST_SETUP;
        end else begin
          state_next = pbc_pkg::ST_EMIT;
        end
      end
      pbc_pkg::ST_SETUP: state_next = pbc_pkg::ST_MUL;
      pbc_pkg::ST_MUL: begin
        cnt_next   = '0;
        state_next = pbc_pkg::ST_DIV;
      end
      pbc_pkg::ST_DIV: begin
        cnt_next = cnt + CNT_BITS'(1);
        if (cnt == CNT_BITS'(W - 1)) begin
          state_next = pbc_pkg::ST_ROUND;
        end
      end
      pbc_pkg::ST_ROUND: state_next = pbc_pkg::ST_EMIT;
      pbc_pkg::ST_EMIT: begin
        if (!out_valid || out_ready) begin
          emit_fire  = 1'b1;
          mask_next  = mask & ~step;
          state_next = pbc_pkg::ST_PICK;
        end
      end
      default: state_next = pbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prev_x <= vert_x;
      prev_y <= vert_y;
      pa_x   <= vert_x;
      pa_y   <= vert_y;
      sa_x   <= have_first ? prev_x : vert_x;
      sa_y   <= have_first ? prev_y : vert_y;
      a_p_in <= cur_in;
      b_p_in <= fst_in;
      last_r <= poly_last;
      if (!have_first) begin
        first_x <= vert_x;
        first_y <= vert_y;
      end
    end
    case (state)
      pbc_pkg::ST_PICK: begin
        res_cr <= 1'b0;
        res_hv <= (low_bit != pbc_pkg::STEP_MARK);
        case (low_bit)
          pbc_pkg::STEP_A_VERT: begin
            res_x <= pa_x;
            res_y <= pa_y;
          end
          pbc_pkg::STEP_B_VERT: begin
            res_x <= first_x;
            res_y <= first_y;
          end
          default: begin
            res_x <= '0;
            res_y <= '0;
          end
        endcase
      end
      pbc_pkg::ST_SETUP: begin
        mag_t  <= t_m[W-1:0];
        mag_dv <= dv_m[W-1:0];
        dm     <= d_m[W-1:0];
        neg    <= t_d[W] ^ dv_d[W] ^ d_d[W];
        av_r   <= av;
      end
      pbc_pkg::ST_MUL: begin
        rem <= prod[2*W-1:W];
        quo <= prod[W-1:0];
      end
      pbc_pkg::ST_DIV: begin
        rem <= ge ? diff[W-1:0] : trial[W-1:0];
        quo <= {quo[W-2:0], ge};
      end
      pbc_pkg::ST_ROUND: begin
        res_hv <= 1'b1;
        res_cr <= 1'b1;
        res_x  <= y_axis ? cross_c : bound;
        res_y  <= y_axis ? bound : cross_c;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_x       <= res_x;
      out_y       <= res_y;
      has_vertex  <= res_hv;
      is_crossing <= res_cr;
      poly_end    <= last_r && ((mask & ~step) == pbc_pkg::STEP_NONE);
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ready)
    else $error("input taken while an item is still in work");

  a_idle_plan_empty: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (mask == pbc_pkg::STEP_NONE))
    else $error("idle with results still planned");

  a_step_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0(step))
    else $error("more than one step selected");

  a_marker_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !has_vertex) |-> (poly_end && !is_crossing))
    else $error("end-only marker without end flag or with crossing flag");

  a_crossing_on_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_crossing && !y_axis) |-> (out_x == bound))
    else $error("crossing off the boundary line");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the polygon boundary clip stage
// Streams polygons through one clipping pass under every boundary side and
// several boundary values, with random idle cycles on both channels. A
// built-in predictor of the pass supplies the expected output vertices,
// which are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CW = pbc_pkg::COORD_BITS_DEF;

  typedef struct packed {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          hv;
    logic          cr;
    logic          pe;
  } clip_out_t;

  typedef enum int {ROW_PREDICT, ROW_NOTHING, ROW_ONE} row_kind_t;

  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic          is_last;
    row_kind_t     kind;
    clip_out_t     pt;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst;
  logic in_valid;
  logic in_ready;
  logic [CW-1:0] vert_x;
  logic [CW-1:0] vert_y;
  logic poly_last;
  logic out_valid;
  logic out_ready = 1'b1;
  logic [CW-1:0] out_x;
  logic [CW-1:0] out_y;
  logic has_vertex;
  logic is_crossing;
  logic poly_end;
  logic cfg_valid;
  logic cfg_ready;
  logic [pbc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [CW-1:0] cfg_data;

  pbc_pkg::side_t clip_side;
  longint    clip_bound;
  longint    orig_x, orig_y, last_x, last_y;
  bit        open_poly;
  clip_out_t step_pts[$];
  clip_out_t pending_pts[$];
  dir_row_t  dir_rows[$];
  bit        calm;
  int        fail_cnt = 0;
  int        hold_cnt = 0;

  polygon_boundary_clip_stage u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .vert_x      (vert_x),
    .vert_y      (vert_y),
    .poly_last   (poly_last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_x       (out_x),
    .out_y       (out_y),
    .has_vertex  (has_vertex),
    .is_crossing (is_crossing),
    .poly_end    (poly_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic bit in_bounds(input longint x, input longint y);
    case (clip_side)
      pbc_pkg::SIDE_LEFT:  return x >= clip_bound;
      pbc_pkg::SIDE_RIGHT: return x <= clip_bound;
      pbc_pkg::SIDE_TOP:   return y >= clip_bound;
      default:             return y <= clip_bound;
    endcase
  endfunction

  // Coordinate along the edge where it meets the boundary, rounded to nearest
  // with ties toward positive infinity.
  function automatic longint meet_coord(input longint au, input longint av,
                                        input longint bu, input longint bv);
    longint t, dv, d, num, den, q, r;
    bit neg;
    t = clip_bound - au;
    dv = bv - av;
    d = bu - au;
    if (d == 0 || t == 0 || dv == 0) return av;
    neg = ((t < 0) != (dv < 0)) != (d < 0);
    num = (t < 0 ? -t : t) * (dv < 0 ? -dv : dv);
    den = d < 0 ? -d : d;
    q = num / den;
    r = num % den;
    if (neg) return av - (q + ((2 * r > den) ? 1 : 0));
    return av + q + ((2 * r >= den) ? 1 : 0);
  endfunction

  function automatic void add_pt(input longint x, input longint y, input bit hv,
                                 input bit cr);
    clip_out_t p;
    p.x = x[CW-1:0];
    p.y = y[CW-1:0];
    p.hv = hv;
    p.cr = cr;
    p.pe = 1'b0;
    step_pts.insert(step_pts.size(), p);
  endfunction

  function automatic void add_meet(input longint ix, input longint iy, input longint ox,
                                   input longint oy);
    if (clip_side == pbc_pkg::SIDE_LEFT || clip_side == pbc_pkg::SIDE_RIGHT)
      add_pt(clip_bound, meet_coord(ix, iy, ox, oy), 1'b1, 1'b1);
    else
      add_pt(meet_coord(iy, ix, oy, ox), clip_bound, 1'b1, 1'b1);
  endfunction

  function automatic void trim_segment(input longint sx, input longint sy, input longint px,
                                       input longint py);
    bit s_in, p_in;
    s_in = in_bounds(sx, sy);
    p_in = in_bounds(px, py);
    if (p_in) begin
      if (!s_in) add_meet(px, py, sx, sy);
      add_pt(px, py, 1'b1, 1'b0);
    end else if (s_in) begin
      add_meet(sx, sy, px, py);
    end
  endfunction

  function automatic void clip_vertex(input logic [CW-1:0] vx, input logic [CW-1:0] vy,
                                      input logic is_last);
    longint x, y;
    x = $signed(vx);
    y = $signed(vy);
    step_pts.delete();
    if (!open_poly) begin
      orig_x = x;
      orig_y = y;
      last_x = x;
      last_y = y;
      if (!is_last) begin
        open_poly = 1'b1;
        return;
      end
      trim_segment(x, y, x, y);
    end else begin
      trim_segment(last_x, last_y, x, y);
      if (is_last) trim_segment(x, y, orig_x, orig_y);
      last_x = x;
      last_y = y;
    end
    if (is_last) begin
      open_poly = 1'b0;
      if (step_pts.size() == 0) add_pt(0, 0, 1'b0, 1'b0);
      step_pts[step_pts.size()-1].pe = 1'b1;
    end
  endfunction

  function automatic void add_row(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                  input logic is_last, input row_kind_t kind,
                                  input clip_out_t pt);
    dir_row_t r;
    r.x = x;
    r.y = y;
    r.is_last = is_last;
    r.kind = kind;
    r.pt = pt;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  function automatic void cmp_field(input string name, input logic [CW-1:0] want,
                                    input logic [CW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_cnt++;
    end
  endfunction

  function automatic logic [CW-1:0] pick_coord(input longint centre);
    case ($urandom_range(0, 9))
      0:       return CW'($urandom());
      1:       return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return CW'(centre + longint'($urandom_range(0, 32768)) - 16384);
    endcase
  endfunction

  task automatic push_vertex(input logic [CW-1:0] x, input logic [CW-1:0] y,
                             input logic is_last);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    vert_x <= x;
    vert_y <= y;
    poly_last <= is_last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_checked(input logic [CW-1:0] x, input logic [CW-1:0] y,
                              input logic is_last);
    push_vertex(x, y, is_last);
    clip_vertex(x, y, is_last);
    foreach (step_pts[i]) pending_pts.insert(pending_pts.size(), step_pts[i]);
  endtask

  task automatic write_reg(input logic [pbc_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [CW-1:0] data);
    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == pbc_pkg::REG_SIDE)
      clip_side = pbc_pkg::side_t'(data[1:0]);
    else
      clip_bound = $signed(data);
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: unexpected item, expected none, got x=%h y=%h hv=%b cr=%b end=%b",
                 $time, out_x, out_y, has_vertex, is_crossing, poly_end);
        fail_cnt++;
      end else begin
        clip_out_t want;
        want = pending_pts.pop_front();
        cmp_field("out_x", want.x, out_x);
        cmp_field("out_y", want.y, out_y);
        cmp_field("has_vertex", CW'(want.hv), CW'(has_vertex));
        cmp_field("is_crossing", CW'(want.cr), CW'(is_crossing));
        cmp_field("poly_end", CW'(want.pe), CW'(poly_end));
      end
      hold_cnt = calm ? 0 : $urandom_range(0, 10);
      out_ready <= (hold_cnt == 0);
    end else if (hold_cnt != 0) begin
      hold_cnt--;
      if (hold_cnt == 0) out_ready <= 1'b1;
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  initial begin
    pbc_pkg::side_t side;
    logic [CW-1:0] bnd;
    logic [CW-1:0] side_word;
    int n;
    int vert_cnt;
    rst <= 1'b1;
    in_valid <= 1'b0;
    vert_x <= '0;
    vert_y <= '0;
    poly_last <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= pbc_pkg::REG_SIDE;
    cfg_data <= '0;
    clip_side = pbc_pkg::SIDE_LEFT;
    clip_bound = 0;
    open_poly = 1'b0;
    calm = 1'b0;
    vert_cnt = 0;

    add_row(24'h000100, 24'h000200, 1'b1, ROW_ONE, '{24'h000100, 24'h000200, 1, 0, 1});
    add_row(24'hFFFF00, 24'h000300, 1'b1, ROW_ONE, '{24'h0, 24'h0, 0, 0, 1});
    add_row(24'h7FFFFF, 24'h7FFFFF, 1'b1, ROW_ONE, '{24'h7FFFFF, 24'h7FFFFF, 1, 0, 1});
    add_row(24'h800000, 24'h800000, 1'b1, ROW_ONE, '{24'h0, 24'h0, 0, 0, 1});
    add_row(24'h000000, 24'h800000, 1'b1, ROW_ONE, '{24'h000000, 24'h800000, 1, 0, 1});
    add_row(24'hFFF000, 24'h000000, 1'b0, ROW_NOTHING, '0);
    add_row(24'h001000, 24'h001000, 1'b0, ROW_PREDICT, '0);
    add_row(24'h001000, 24'hFFF000, 1'b1, ROW_PREDICT, '0);
    add_row(24'hFFFF00, 24'h000100, 1'b0, ROW_NOTHING, '0);
    add_row(24'hFFFE00, 24'h000500, 1'b0, ROW_NOTHING, '0);
    add_row(24'hFFFD00, 24'hFFFF00, 1'b1, ROW_ONE, '{24'h0, 24'h0, 0, 0, 1});
    add_row(24'h800000, 24'h800000, 1'b0, ROW_NOTHING, '0);
    add_row(24'h7FFFFF, 24'h7FFFFF, 1'b0, ROW_PREDICT, '0);
    add_row(24'h7FFFFF, 24'h800000, 1'b0, ROW_PREDICT, '0);
    add_row(24'h800000, 24'h7FFFFF, 1'b1, ROW_PREDICT, '0);
    add_row(24'h000001, 24'h000001, 1'b0, ROW_NOTHING, '0);
    add_row(24'hFFFFFF, 24'h000000, 1'b0, ROW_PREDICT, '0);
    add_row(24'hFFFFFF, 24'h000003, 1'b1, ROW_PREDICT, '0);
    add_row(24'h000500, 24'h000100, 1'b0, ROW_NOTHING, '0);
    add_row(24'h000500, 24'h000900, 1'b0, ROW_PREDICT, '0);
    add_row(24'hFFFB00, 24'h000300, 1'b1, ROW_PREDICT, '0);
    add_row(24'h000200, 24'h000200, 1'b0, ROW_NOTHING, '0);
    add_row(24'h000200, 24'h000200, 1'b1, ROW_PREDICT, '0);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_PREDICT) begin
        send_checked(dir_rows[i].x, dir_rows[i].y, dir_rows[i].is_last);
      end else begin
        push_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].is_last);
        clip_vertex(dir_rows[i].x, dir_rows[i].y, dir_rows[i].is_last);
        if (dir_rows[i].kind == ROW_ONE)
          pending_pts.insert(pending_pts.size(), dir_rows[i].pt);
      end
      vert_cnt++;
    end

    while (vert_cnt < 250) begin
      side = pbc_pkg::side_t'($urandom_range(0, 3));
      side_word = CW'($urandom());
      side_word[1:0] = side;
      case ($urandom_range(0, 5))
        0:       bnd = 24'h7FFFFF;
        1:       bnd = 24'h800000;
        2:       bnd = '0;
        3:       bnd = CW'($urandom());
        default: bnd = CW'(longint'($urandom_range(0, 131072)) - 65536);
      endcase
      if ($urandom_range(0, 1)) begin
        write_reg(pbc_pkg::REG_SIDE, side_word);
        write_reg(pbc_pkg::REG_BOUND, bnd);
      end else begin
        write_reg(pbc_pkg::REG_BOUND, bnd);
        write_reg(pbc_pkg::REG_SIDE, side_word);
      end
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 7);
        for (int k = 0; k < n; k++) begin
          send_checked(pick_coord(clip_bound), pick_coord(clip_bound), k == n - 1);
          vert_cnt++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_cnt == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

endmodule

### filelist.f
design/pbc_pkg.sv
design/polygon_boundary_clip_stage.sv
tb/tb_top.sv
